FILE: rtl/sprite_scanline_evaluation_macros.svh
// assertion macros shared by the sprite scanline evaluation design
`ifndef SPRITE_SCANLINE_EVALUATION_MACROS_SVH
`define SPRITE_SCANLINE_EVALUATION_MACROS_SVH

// same-cycle implication, checked out of reset
`define SSE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define SSE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/spr_eval_pkg.sv
// types and constants shared by the sprite scanline evaluation modules
package spr_eval_pkg;

   // request kinds carried on tuser
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_EVAL  = 1'b1;

   // stream widths
   localparam int REQ_W = 24;
   localparam int RSP_W = 56;

   // selection rules
   localparam logic [7:0] Y_UPPER      = 8'hEF;
   localparam logic [7:0] SHORT_HEIGHT = 8'd8;
   localparam logic [7:0] TALL_HEIGHT  = 8'd16;
   localparam int         NUM_SLOTS    = 8;
   localparam int         SLOT_IDX_W   = $clog2(NUM_SLOTS);
   localparam int         SLOT_W       = 6;
   localparam int         COUNT_W      = 4;
   localparam int         SPRITES_PER_LINE = 8;

   // response field positions
   localparam int COUNT_LSB = NUM_SLOTS * SLOT_W;
   localparam int OVF_BIT   = COUNT_LSB + COUNT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic write;
      logic issue;
      logic publish;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_issue;
      logic rsp_free;
   } dp_status_type;

endpackage

FILE: rtl/spr_eval_ctrl.sv
// sequencer for attribute writes and the entry scan of one evaluation
module spr_eval_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic                       req_func,
   input  spr_eval_pkg::dp_status_type status,
   output spr_eval_pkg::dp_cmd_type    cmd
);
   import spr_eval_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_func == FUNC_EVAL) begin
                  cmd.start = 1'b1;
                  state_in  = ST_SCAN;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (status.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/spr_eval_dp.sv
// y-byte store, range compare, slot collection and response register
module spr_eval_dp #(
   parameter int SPRITE_ENTRIES = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  spr_eval_pkg::dp_cmd_type         cmd,
   output spr_eval_pkg::dp_status_type      status,
   input  logic                            csr_wr_en,
   input  logic                            csr_wr_data,
   input  logic [spr_eval_pkg::REQ_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [spr_eval_pkg::RSP_W-1:0]  rsp_tdata
);
   import spr_eval_pkg::*;

   localparam int EW = $clog2(SPRITE_ENTRIES);

   // request fields
   logic [7:0] oam_addr;
   logic [7:0] oam_data;
   logic [7:0] scanline;
   logic [5:0] wr_entry;
   logic       wr_hit;
   logic [EW-1:0] wr_idx;

   assign oam_addr = req_tdata[7:0];
   assign oam_data = req_tdata[15:8];
   assign scanline = req_tdata[23:16];
   assign wr_entry = oam_addr[7:2];
   assign wr_idx   = wr_entry[EW-1:0];
   // only the y byte of an entry in range affects evaluation
   assign wr_hit   = cmd.write && (oam_addr[1:0] == 2'b00)
                     && (32'(wr_entry) < SPRITE_ENTRIES);

   // configuration register
   logic tall_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         tall_ff <= 1'b0;
      end else if (csr_wr_en) begin
         tall_ff <= csr_wr_data;
      end
   end

   // y-byte memory, one read port with registered data
   logic [7:0]                ymem [SPRITE_ENTRIES];
   logic [SPRITE_ENTRIES-1:0] yvld_ff;
   logic [7:0]                rd_y_ff;
   logic                      rd_vld_ff;
   logic [EW-1:0]             rd_idx_ff;
   logic [EW-1:0]             ev_idx_ff;

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         ymem[wr_idx] <= oam_data;
      end
      rd_y_ff   <= ymem[rd_idx_ff];
      rd_vld_ff <= yvld_ff[rd_idx_ff];
   end

   // per-entry written flags, unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         yvld_ff <= '0;
      end else if (wr_hit) begin
         yvld_ff[wr_idx] <= 1'b1;
      end
   end

   // scan address and read-pending flag
   logic pend_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         pend_ff <= cmd.issue;
         if (cmd.start) begin
            rd_idx_ff <= '0;
         end else if (cmd.issue) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         ev_idx_ff <= rd_idx_ff;
      end
   end

   assign status.last_issue = (rd_idx_ff == EW'(SPRITE_ENTRIES - 1));

   // scanline of the current evaluation
   logic [7:0] line_ff;
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         line_ff <= scanline;
      end
   end

   // range test on the returned y byte
   logic [7:0] y_val;
   logic [7:0] height;
   logic [7:0] diff;
   logic       hit;
   logic       full_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W:0]   count_sum;

   assign y_val     = rd_vld_ff ? rd_y_ff : 8'h00;
   assign height    = tall_ff ? TALL_HEIGHT : SHORT_HEIGHT;
   assign diff      = line_ff - y_val;
   assign hit       = pend_ff && !full_ff && (y_val != 8'h00) && (y_val < Y_UPPER)
                      && (line_ff >= y_val) && (diff < height);
   assign count_sum = {1'b0, count_ff} + 1'b1;

   // slot collection
   logic [SLOT_W-1:0] slots_ff [NUM_SLOTS];
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         full_ff  <= 1'b0;
      end else if (cmd.start) begin
         count_ff <= '0;
         full_ff  <= 1'b0;
      end else if (hit) begin
         count_ff <= count_sum[COUNT_W] ? '1 : count_sum[COUNT_W-1:0];
         full_ff  <= (32'(count_sum) >= SPRITES_PER_LINE);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slots_ff[i] <= '0;
         end
      end else if (hit && (32'(count_ff) < NUM_SLOTS)) begin
         slots_ff[count_ff[SLOT_IDX_W-1:0]] <= SLOT_W'(ev_idx_ff);
      end
   end

   // response register
   logic             rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;
   logic [RSP_W-1:0] rsp_data_in;

   always_comb begin
      rsp_data_in = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         rsp_data_in[i*SLOT_W +: SLOT_W] = slots_ff[i];
      end
      rsp_data_in[COUNT_LSB +: COUNT_W] = count_ff;
      rsp_data_in[OVF_BIT]              = full_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign status.rsp_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

endmodule

FILE: rtl/sprite_scanline_evaluation.sv
// top level of the sprite scanline evaluation block
//
//  channel | dir | beat fields
//  --------+-----+----------------------------------------------------------
//  req_    | in  | tuser: func; tdata: oam_addr, oam_data, scanline
//  rsp_    | out | tdata: slot_0..slot_7, sprite_count, overflow
//  csr_    | in  | wr_data: tall_sprites, taken whenever wr_en is high
//
//  a write beat gives no response and leaves the block ready for the next beat
//  an evaluate beat reads one entry per cycle over the single memory read port:
//  the response is registered in ST_FINISH once the response register is free
//  the next beat is taken only after the scan, ST_DRAIN and ST_FINISH
//  reset clears the per-entry written flags at once, no clearing pass
//  a waiting response stalls only the next evaluation, at its final cycle
`include "sprite_scanline_evaluation_macros.svh"

module sprite_scanline_evaluation #(
   parameter int SPRITE_ENTRIES = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   // csr
   input  logic                            csr_wr_en,
   input  logic                            csr_wr_data,  // tall_sprites
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic                            req_tuser,    // func
   input  logic [spr_eval_pkg::REQ_W-1:0]  req_tdata,    // oam_addr, oam_data, scanline
   // response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [spr_eval_pkg::RSP_W-1:0]  rsp_tdata     // slot_0..7, sprite_count, overflow
);
   import spr_eval_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // sequencer
   spr_eval_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

   // datapath
   spr_eval_dp #(
      .SPRITE_ENTRIES (SPRITE_ENTRIES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (dp_cmd),
      .status      (dp_status),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // checks
   `SSE_ASSERT_NEXT(a_eval_blocks_req,
                    req_tvalid && req_tready && (req_tuser == FUNC_EVAL),
                    !req_tready,
                    "evaluate beat did not start a scan")
   `SSE_ASSERT_SAME(a_write_on_accept,
                    dp_cmd.write,
                    req_tvalid && req_tready,
                    "memory write without an accepted beat")
   `SSE_ASSERT_SAME(a_publish_free,
                    dp_cmd.publish,
                    !rsp_tvalid || rsp_tready,
                    "response overwritten before taken")
   `SSE_ASSERT_SAME(a_ovf_matches_count,
                    rsp_tvalid,
                    rsp_tdata[OVF_BIT] ==
                       (32'(rsp_tdata[COUNT_LSB +: COUNT_W]) >= SPRITES_PER_LINE),
                    "overflow flag disagrees with count")

endmodule

FILE: tb/tb_sprite_scanline_evaluation.sv
// testbench for the sprite scanline evaluation block: directed and random beats vs a predictor
`timescale 1ns / 100ps

module tb_sprite_scanline_evaluation;
   import spr_eval_pkg::*;

   localparam int SPRITE_TOTAL  = 64;
   localparam int SETTLE_CYCLES = 100;
   localparam int HOLD_CYCLES   = 500;
   localparam int CYCLE_LIMIT   = 600000;

   // one evaluated scanline as the block reports it
   typedef struct packed {
      logic [NUM_SLOTS-1:0][SLOT_W-1:0] slots;
      logic [COUNT_W-1:0]               count;
      logic                             overflow;
   } sprite_line_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             csr_wr_en   = 1'b0;
   logic             csr_wr_data = 1'b0;
   logic             req_tvalid  = 1'b0;
   logic             req_tready;
   logic             req_tuser   = FUNC_WRITE;  // func
   logic [REQ_W-1:0] req_tdata   = '0;          // oam_addr, oam_data, scanline
   logic             rsp_tvalid;
   logic             rsp_tready  = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;                 // slot_0..slot_7, sprite_count, overflow

   // predictor state
   logic [7:0]      oam_model [256];
   logic            tall_model;
   sprite_line_type expected_lines[$];

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   bit  idling_on      = 1'b1;
   int  hold_orders    = 0;
   int  hold_served    = 0;
   int  hold_left      = 0;
   int  rx_gap         = 0;

   sprite_scanline_evaluation #(
      .SPRITE_ENTRIES(SPRITE_TOTAL)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run limit reached", $time);
         $display("TB_ERROR");
         $finish;
      end
   end

   // scan entries in order, keep up to eight in-range sprites
   function automatic sprite_line_type predict_sprite_line(input logic [7:0] line);
      sprite_line_type r;
      logic [7:0]      y;
      logic [7:0]      height;
      int              found;
      r      = '0;
      found  = 0;
      height = tall_model ? TALL_HEIGHT : SHORT_HEIGHT;
      for (int e = 0; e < SPRITE_TOTAL && found < SPRITES_PER_LINE; e++) begin
         y = oam_model[e * 4];
         if (y != 8'd0 && y < Y_UPPER && line >= y && (line - y) < height) begin
            if (found < NUM_SLOTS) r.slots[found] = 6'(e);
            found++;
         end
      end
      r.count    = 4'(found);
      r.overflow = (found >= SPRITES_PER_LINE);
      return r;
   endfunction

   // receiver: random stalls, plus long holds on request
   always @(posedge clock) begin
      if (hold_served != hold_orders) begin
         hold_served = hold_orders;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (rx_gap != 0) begin
         rx_gap--;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
         rx_gap = $urandom_range(1, 13) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare each response beat with the oldest predicted line
   always @(posedge clock) begin
      sprite_line_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_lines.size() == 0) begin
            $display("%0t: response beat expected none actual %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_lines.pop_front();
            for (int s = 0; s < NUM_SLOTS; s++) begin
               if (rsp_tdata[s * SLOT_W +: SLOT_W] !== want.slots[s]) begin
                  $display("%0t: slot_%0d expected %0d actual %0d", $time, s,
                           want.slots[s], rsp_tdata[s * SLOT_W +: SLOT_W]);
                  mismatch_count++;
               end
            end
            if (rsp_tdata[COUNT_LSB +: COUNT_W] !== want.count) begin
               $display("%0t: sprite_count expected %0d actual %0d", $time,
                        want.count, rsp_tdata[COUNT_LSB +: COUNT_W]);
               mismatch_count++;
            end
            if (rsp_tdata[OVF_BIT] !== want.overflow) begin
               $display("%0t: overflow expected %0d actual %0d", $time,
                        want.overflow, rsp_tdata[OVF_BIT]);
               mismatch_count++;
            end
         end
      end
   end

   // offer one beat, keep valid high afterwards for back-to-back beats
   task automatic send_beat(input logic func, input logic [7:0] addr,
                            input logic [7:0] data, input logic [7:0] line);
      int gap;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 13);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {line, data, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (func == FUNC_WRITE) oam_model[addr] = data;
      else expected_lines.push_back(predict_sprite_line(line));
   endtask

   task automatic write_byte(input logic [7:0] addr, input logic [7:0] data);
      send_beat(FUNC_WRITE, addr, data, 8'($urandom));
   endtask

   task automatic eval_line(input logic [7:0] line);
      send_beat(FUNC_EVAL, 8'($urandom), 8'($urandom), line);
   endtask

   // drop valid, wait for all responses and for the scan to wind down
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_tall(input logic tall);
      settle_block();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= tall;
      @(posedge clock);
      tall_model = tall;
      csr_wr_en <= 1'b0;
   endtask

   // memory is all zero after reset, nothing selected
   task automatic test_cleared_memory();
      eval_line(8'd0);
      eval_line(8'd239);
   endtask

   // y of 0 and 0xef never selected, scanlines past 239
   task automatic test_y_bounds();
      write_byte(8'd0, 8'd1);
      eval_line(8'd1);
      eval_line(8'd8);
      eval_line(8'd9);
      write_byte(8'd252, Y_UPPER);
      write_byte(8'd248, Y_UPPER - 8'd1);
      eval_line(8'hEE);
      eval_line(8'hF5);
      eval_line(8'hFF);
      write_byte(8'd255, 8'hFF);
      write_byte(8'd1, 8'hAA);
   endtask

   // nine sprites on one line, only eight taken
   task automatic test_eight_limit();
      for (int e = 20; e < 29; e++) write_byte(8'(e * 4), 8'd100);
      eval_line(8'd100);
      eval_line(8'd107);
   endtask

   // height 16 reaches rows 8..15 below y
   task automatic test_tall_height();
      set_tall(1'b1);
      eval_line(8'd115);
      eval_line(8'd116);
      set_tall(1'b0);
   endtask

   // mostly y writes and evaluations clustered around a moving band
   task automatic run_random_traffic(input int n_items);
      logic [7:0] band;
      logic [7:0] data;
      int         pick;
      int         entry;
      band = 8'($urandom_range(1, 8'hF0));
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(0, 49) == 0) band = 8'($urandom_range(1, 8'hF0));
         pick  = $urandom_range(0, 99);
         entry = $urandom_range(0, SPRITE_TOTAL - 1);
         if (pick < 45) begin
            case ($urandom_range(0, 19))
               0:       data = 8'd0;
               1:       data = 8'($urandom_range(Y_UPPER, 8'hFF));
               default: data = 8'(band + $urandom_range(0, 12));
            endcase
            write_byte(8'(entry * 4), data);
         end else if (pick < 58) begin
            write_byte(8'(entry * 4 + $urandom_range(1, 3)), 8'($urandom));
         end else if ($urandom_range(0, 9) == 0) begin
            eval_line(8'($urandom));
         end else begin
            eval_line(8'(band + $urandom_range(0, 24)));
         end
      end
   endtask

   task automatic test_random_settings();
      for (int p = 0; p < 5; p++) begin
         set_tall(p[0]);
         run_random_traffic(200);
      end
   endtask

   // receiver holds off while evaluations keep coming
   task automatic test_backpressure();
      logic [7:0] band;
      settle_block();
      band = 8'($urandom_range(40, 120));
      for (int e = 0; e < 12; e++) write_byte(8'(e * 4), 8'(band + $urandom_range(0, 6)));
      hold_orders++;
      for (int i = 0; i < 20; i++) eval_line(8'(band + $urandom_range(0, 12)));
   endtask

   // back-to-back traffic, no idling on either side
   task automatic test_steady_stream();
      settle_block();
      idling_on = 1'b0;
      run_random_traffic(200);
   endtask

   initial begin
      for (int a = 0; a < 256; a++) oam_model[a] = 8'd0;
      tall_model = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_cleared_memory();
      test_y_bounds();
      test_eight_limit();
      test_tall_height();
      test_random_settings();
      test_backpressure();
      test_steady_stream();
      settle_block();

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: sprite_scanline_evaluation.f
+incdir+rtl
rtl/spr_eval_pkg.sv
rtl/spr_eval_ctrl.sv
rtl/spr_eval_dp.sv
rtl/sprite_scanline_evaluation.sv
tb/tb_sprite_scanline_evaluation.sv
